[hdl/rsh_pkg.sv]
`default_nettype none
package rsh_pkg;

    localparam int MAX_SPHERES = 16;
    localparam int FRAC_BITS   = 16;

    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int POS_W   = 32;
    localparam int DIR_W   = 18;
    localparam int RAD_W   = 31;
    localparam int R2_W    = 2 * RAD_W;
    localparam int DIST_W  = 32;

    localparam int L_W    = POS_W + 1;
    localparam int MUL_W  = L_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int TCA_W  = L_W + DIR_W + 2;
    localparam int TQ_W   = TCA_W - FRAC_BITS;
    localparam int LL_W   = 2 * L_W + 1;
    localparam int TD_W   = TQ_W + 1;
    localparam int SQ_W   = 64;
    localparam int SQK_W  = 5;
    localparam int THC_W  = R2_W / 2;
    localparam int STEP_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SPHERES);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RAY  = 1'b1;

    localparam logic [STEP_W-1:0] STEP_DX  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DY  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DZ  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LX  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LY  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LZ  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_TQ  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_L,
        ST_MUL,
        ST_D2,
        ST_SQRT,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                sph_load;
        logic                ray_load;
        logic                rd;
        logic                lcalc;
        logic                mul;
        logic [STEP_W-1:0]   mstep;
        logic                d2;
        logic                sqrt;
        logic                fin;
        logic                push;
        logic [SLOT_W-1:0]   idx;
    } cmd_t;

    typedef struct packed {
        logic miss;
        logic sqrt_last;
    } status_t;

endpackage
`default_nettype wire

[hdl/rsh_if.sv]
`default_nettype none
interface rsh_req_if;
    import rsh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [RAD_W-1:0]        radius;
    modport source (output valid, mode, slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                    radius, input ready);
    modport sink (input valid, mode, slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  radius, output ready);
endinterface

interface rsh_rsp_if;
    import rsh_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [DIST_W-1:0] hit_distance;
    modport source (output valid, hit, hit_slot, hit_distance, input ready);
    modport sink (input valid, hit, hit_slot, hit_distance, output ready);
endinterface

interface rsh_cfg_if;
    import rsh_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hdl/rsh_ctrl.sv]
`default_nettype none
module rsh_ctrl
    import rsh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic               req_mode,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire status_t            status,
    output cmd_t                    cmd
);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [COUNT_W-1:0]  active_n;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign active_n  = (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.mstep      = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    if (req_mode == MODE_LOAD)
                    begin
                        cmd.sph_load = 1'b1;
                    end
                    else
                    begin
                        cmd.ray_load = 1'b1;
                        idx_next     = '0;
                        state_next   = (active_n == '0) ? ST_DONE : ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_L;
            end
            ST_L:
            begin
                cmd.lcalc  = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul   = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_TQ)
                begin
                    state_next = ST_D2;
                end
            end
            ST_D2:
            begin
                cmd.d2     = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                // skip the root on a miss
                cmd.sqrt = !status.miss;
                if (status.miss || status.sqrt_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if ({1'b0, idx_reg} + 1'b1 == active_n)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.push       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/rsh_datapath.sv]
`default_nettype none
module rsh_datapath
    import rsh_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [SLOT_W-1:0]       slot,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic signed [DIR_W-1:0] dir_x,
    input  wire logic signed [DIR_W-1:0] dir_y,
    input  wire logic signed [DIR_W-1:0] dir_z,
    input  wire logic [RAD_W-1:0]        radius,
    input  wire cmd_t                    cmd,
    output status_t                      status,
    output logic                         hit,
    output logic [SLOT_W-1:0]            hit_slot,
    output logic [DIST_W-1:0]            hit_distance
);

    logic signed [POS_W-1:0] cx_mem [MAX_SPHERES];
    logic signed [POS_W-1:0] cy_mem [MAX_SPHERES];
    logic signed [POS_W-1:0] cz_mem [MAX_SPHERES];
    logic [R2_W-1:0]         r2_mem [MAX_SPHERES];

    logic signed [POS_W-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [DIR_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [POS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [R2_W-1:0]         r2_reg;
    logic signed [L_W-1:0]   lx_reg, ly_reg, lz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TCA_W-1:0] tca_reg;
    logic [LL_W-1:0]         ll_reg;
    logic                    miss_reg;
    logic [SQ_W-1:0]         rem_reg, res_reg;
    logic [SQK_W-1:0]        k_reg;
    logic                    found_reg;
    logic [TD_W-1:0]         best_reg;
    logic [SLOT_W-1:0]       best_slot_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hit_slot_reg;
    logic [DIST_W-1:0]       hit_dist_reg;

    logic signed [MUL_W-1:0] ma, mb;
    logic [L_W-1:0]          mag_x, mag_y, mag_z;
    logic [TQ_W-1:0]         tq;
    logic                    tq_big;
    logic [LL_W-1:0]         tqsq;
    logic [LL_W-1:0]         diff;
    logic                    d2_zero;
    logic [SQ_W-1:0]         sq_bit, sq_try;
    logic [THC_W-1:0]        thc;
    logic [TD_W-1:0]         cand_dist;

    function automatic logic [L_W-1:0] mag(input logic signed [L_W-1:0] v);
        return v[L_W-1] ? L_W'(-v) : L_W'(v);
    endfunction

    assign mag_x  = mag(lx_reg);
    assign mag_y  = mag(ly_reg);
    assign mag_z  = mag(lz_reg);
    assign tq     = tca_reg[TCA_W-1:FRAC_BITS];
    assign tq_big = |tq[TQ_W-1:L_W];

    always_comb
    begin
        case (cmd.mstep)
            STEP_DX: begin ma = MUL_W'(lx_reg); mb = MUL_W'(dx_reg); end
            STEP_DY: begin ma = MUL_W'(ly_reg); mb = MUL_W'(dy_reg); end
            STEP_DZ: begin ma = MUL_W'(lz_reg); mb = MUL_W'(dz_reg); end
            STEP_LX: begin ma = $signed({1'b0, mag_x}); mb = $signed({1'b0, mag_x}); end
            STEP_LY: begin ma = $signed({1'b0, mag_y}); mb = $signed({1'b0, mag_y}); end
            STEP_LZ: begin ma = $signed({1'b0, mag_z}); mb = $signed({1'b0, mag_z}); end
            STEP_TQ: begin ma = $signed({1'b0, tq[L_W-1:0]}); mb = ma; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // tq at or above 2^33 squares past any reachable l.l
    assign tqsq    = LL_W'(prod_reg);
    assign d2_zero = tq_big || (ll_reg < tqsq);
    assign diff    = ll_reg - tqsq;

    assign sq_bit = SQ_W'(1) << {k_reg, 1'b0};
    assign sq_try = res_reg + sq_bit;

    assign thc       = res_reg[THC_W-1:0];
    assign cand_dist = ({1'b0, tq} >= TD_W'(thc)) ? ({1'b0, tq} - TD_W'(thc))
                                                  : ({1'b0, tq} + TD_W'(thc));

    assign status.miss      = miss_reg;
    assign status.sqrt_last = (k_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.sph_load)
        begin
            cx_mem[slot] <= pos_x;
            cy_mem[slot] <= pos_y;
            cz_mem[slot] <= pos_z;
            r2_mem[slot] <= R2_W'(radius) * R2_W'(radius);
        end
        if (cmd.rd)
        begin
            cx_reg <= cx_mem[cmd.idx];
            cy_reg <= cy_mem[cmd.idx];
            cz_reg <= cz_mem[cmd.idx];
            r2_reg <= r2_mem[cmd.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ray_load)
        begin
            ox_reg    <= pos_x;
            oy_reg    <= pos_y;
            oz_reg    <= pos_z;
            dx_reg    <= dir_x;
            dy_reg    <= dir_y;
            dz_reg    <= dir_z;
            found_reg <= 1'b0;
            best_reg  <= '0;
            best_slot_reg <= '0;
        end
        if (cmd.lcalc)
        begin
            lx_reg  <= L_W'(cx_reg) - L_W'(ox_reg);
            ly_reg  <= L_W'(cy_reg) - L_W'(oy_reg);
            lz_reg  <= L_W'(cz_reg) - L_W'(oz_reg);
            tca_reg <= '0;
            ll_reg  <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= ma * mb;
            // accumulate the product issued on the previous step
            if (cmd.mstep > STEP_DX && cmd.mstep <= STEP_LX)
            begin
                tca_reg <= tca_reg + TCA_W'(prod_reg);
            end
            else if (cmd.mstep > STEP_LX && cmd.mstep <= STEP_TQ)
            begin
                ll_reg <= ll_reg + LL_W'(prod_reg);
            end
        end
        if (cmd.d2)
        begin
            res_reg <= '0;
            k_reg   <= '1;
            if (tca_reg[TCA_W-1])
            begin
                miss_reg <= 1'b1;
                rem_reg  <= '0;
            end
            else if (d2_zero)
            begin
                miss_reg <= 1'b0;
                rem_reg  <= SQ_W'(r2_reg);
            end
            else
            begin
                miss_reg <= diff > LL_W'(r2_reg);
                rem_reg  <= SQ_W'(r2_reg - R2_W'(diff));
            end
        end
        if (cmd.sqrt)
        begin
            k_reg <= k_reg - 1'b1;
            if (rem_reg >= sq_try)
            begin
                rem_reg <= rem_reg - sq_try;
                res_reg <= (res_reg >> 1) + sq_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
        if (cmd.fin && !miss_reg && (!found_reg || cand_dist < best_reg))
        begin
            found_reg     <= 1'b1;
            best_reg      <= cand_dist;
            best_slot_reg <= cmd.idx;
        end
        if (cmd.push)
        begin
            hit_reg      <= found_reg;
            hit_slot_reg <= found_reg ? best_slot_reg : '0;
            if (!found_reg)
            begin
                hit_dist_reg <= '0;
            end
            else if (|best_reg[TD_W-1:DIST_W])
            begin
                hit_dist_reg <= '1;
            end
            else
            begin
                hit_dist_reg <= best_reg[DIST_W-1:0];
            end
        end
    end

    assign hit          = hit_reg;
    assign hit_slot     = hit_slot_reg;
    assign hit_distance = hit_dist_reg;

endmodule
`default_nettype wire

[hdl/ray_sphere_nearest_hit_top.sv]
`default_nettype none
// Nearest ray-sphere hit over a 16-slot sphere table, fixed point Q16.16.
// Channels: req (load or ray request), rsp (one result per ray request),
// cfg (sphere_count write, always ready, write only while idle).
// A load request (mode 0) writes one slot in the accept cycle and
// produces no result; req stays ready.
// A ray request (mode 1) walks slots 0..n-1, n = min(sphere_count, 16).
// Each slot runs through a table read, offset, seven steps of one shared
// 34x34 multiplier (three dot terms, three squares, tca squared), a
// distance check, and a 32-step bit-pair square root of the 62-bit
// residual; a miss skips the root.
// A new request is taken the cycle after the result is registered.
// The result sits in an output register; if rsp stalls, one result waits
// there while the next request is computed, and the block holds in its
// final state until the register frees up.
// Reset clears the controller, sphere_count and the result valid; table
// contents are undefined until loaded.
module ray_sphere_nearest_hit_top
    import rsh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rsh_req_if.sink   req,
    rsh_rsp_if.source rsp,
    rsh_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t status;

    rsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_mode  (req.mode),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg.data),
        .status    (status),
        .cmd       (cmd)
    );

    rsh_datapath u_dp (
        .clk          (clk),
        .slot         (req.slot),
        .pos_x        (req.pos_x),
        .pos_y        (req.pos_y),
        .pos_z        (req.pos_z),
        .dir_x        (req.dir_x),
        .dir_y        (req.dir_y),
        .dir_z        (req.dir_z),
        .radius       (req.radius),
        .cmd          (cmd),
        .status       (status),
        .hit          (rsp.hit),
        .hit_slot     (rsp.hit_slot),
        .hit_distance (rsp.hit_distance)
    );

endmodule
`default_nettype wire

[hdl/rsh_checker.sv]
`default_nettype none
module rsh_checker
    import rsh_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              req_mode,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              rsp_hit,
    input wire logic [SLOT_W-1:0] rsp_hit_slot,
    input wire logic [DIST_W-1:0] rsp_hit_distance
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_distance)
            && $stable(rsp_hit_slot) && $stable(rsp_hit))
    else $error("stalled result changed");

    // a miss reports zero slot and distance
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_hit_slot == '0 && rsp_hit_distance == '0)
    else $error("miss result not cleared");

    // a ray request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode == MODE_RAY |=> !req_ready)
    else $error("ray request did not block input");

    // a load request leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode == MODE_LOAD |=> req_ready)
    else $error("load request blocked input");

endmodule

bind ray_sphere_nearest_hit_top rsh_checker u_rsh_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_mode         (req.mode),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_hit          (rsp.hit),
    .rsp_hit_slot     (rsp.hit_slot),
    .rsp_hit_distance (rsp.hit_distance)
);
`default_nettype wire
